// ===== hw/rtl/evd_pkg.sv =====
// shared types and constants for the drivetrain tick block
// fixed-point scaling, field widths, divisor factors and the multiply-divide request/response
// no dependencies; used by evd_muldiv and ev_drivetrain_sim_step
`default_nettype none

package evd_pkg;

    // fixed point
    localparam int     FRAC_BITS = 16;
    localparam int     DT_FRAC   = 16;
    localparam longint ONE       = longint'(1) << FRAC_BITS;
    localparam int     PEDAL_SHL = FRAC_BITS - 8;

    // field widths
    localparam int PEDAL_W  = 15;
    localparam int DT_W     = 17;
    localparam int MODE_W   = 2;
    localparam int SPEED_W  = 24;
    localparam int TORQUE_W = 25;
    localparam int CHARGE_W = 23;
    localparam int RANGE_W  = 24;
    localparam int POWER_W  = 22;
    localparam int TEMP_W   = 24;
    localparam int REGEN_W  = 23;

    // stream and configuration ports
    localparam int IN_FIELDS_W  = 2 * PEDAL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SPEED_W + TORQUE_W + CHARGE_W + RANGE_W + POWER_W + TEMP_W
                                + REGEN_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = DT_W;

    // arithmetic unit widths
    localparam int OPND_W   = 26;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int DIVD_W   = 32;
    localparam int KDIV_W   = 8;
    localparam int SHIFT_W  = 5;
    localparam int DIV_BITS = 4;
    localparam int DIV_CYCLES = DIVD_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef logic [PEDAL_W-1:0]         pedal_t;
    typedef logic [DT_W-1:0]            dt_t;
    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [SPEED_W-1:0]         speed_t;
    typedef logic [CHARGE_W-1:0]        charge_t;
    typedef logic [RANGE_W-1:0]         range_t;
    typedef logic [TEMP_W-1:0]          temp_t;
    typedef logic signed [OPND_W-1:0]   opnd_t;
    typedef logic signed [OPND_W:0]     wide_t;
    typedef logic [OPND_W-1:0]          mag_t;
    typedef logic [PROD_W-1:0]          prod_t;
    typedef logic [DIVD_W-1:0]          divd_t;
    typedef logic [KDIV_W-1:0]          kdiv_t;
    typedef logic [KDIV_W:0]            trial_t;
    typedef logic [SHIFT_W-1:0]         shamt_t;
    typedef logic [DIV_CNT_W-1:0]       divcnt_t;

    // register indexes
    localparam cfg_idx_t CFG_DRIVE_MODE = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_TIME_STEP  = cfg_idx_t'(1);

    // drive modes
    localparam mode_t MODE_ECO    = mode_t'(0);
    localparam mode_t MODE_NORMAL = mode_t'(1);
    localparam mode_t MODE_SPORT  = mode_t'(2);

    localparam dt_t    DT_RESET     = dt_t'(6554);
    localparam pedal_t PEDAL_FULL   = pedal_t'(25600);
    localparam pedal_t REGEN_THRESH = pedal_t'(1280);

    // state limits
    localparam speed_t  SPEED_MAX   = speed_t'(200 * ONE);
    localparam charge_t CHARGE_FULL = charge_t'(100 * ONE);
    localparam temp_t   TEMP_MIN    = temp_t'(25 * ONE);
    localparam temp_t   TEMP_MAX    = temp_t'(130 * ONE);
    localparam opnd_t   TORQUE_MAX  = opnd_t'(200 * ONE);
    localparam opnd_t   TEMP_BASE   = opnd_t'(25 * ONE);

    // multiplier constants
    localparam opnd_t B_ECO       = opnd_t'(12);
    localparam opnd_t B_SPORT     = opnd_t'(26);
    localparam opnd_t B_NORMAL    = opnd_t'(2);
    localparam opnd_t B_REGEN     = opnd_t'(7);
    localparam opnd_t B_RTORQ     = opnd_t'(4);
    localparam opnd_t B_DRAG      = opnd_t'(25);
    localparam opnd_t B_RNG_ECO   = opnd_t'(8);
    localparam opnd_t B_RNG_SPORT = opnd_t'(21);
    localparam opnd_t B_RNG_NORM  = opnd_t'(11);

    // divisors split into an odd-ish factor and a power of two
    localparam kdiv_t  K_ONE    = kdiv_t'(1);
    localparam kdiv_t  K_FIVE   = kdiv_t'(5);
    localparam kdiv_t  K_DRAG   = kdiv_t'(9);
    localparam kdiv_t  K_SPEED  = kdiv_t'(125);
    localparam kdiv_t  K_P1     = kdiv_t'(225);
    localparam kdiv_t  K_P2     = kdiv_t'(125);
    localparam kdiv_t  K_CHG    = kdiv_t'(45);
    localparam kdiv_t  K_TWENTY5 = kdiv_t'(25);
    localparam shamt_t S_NONE   = shamt_t'(0);
    localparam shamt_t S_HALF   = shamt_t'(1);
    localparam shamt_t S_SPEED  = shamt_t'(DT_FRAC);
    localparam shamt_t S_P1     = shamt_t'(FRAC_BITS + 4);
    localparam shamt_t S_P2     = shamt_t'(FRAC_BITS + 6);
    localparam shamt_t S_CHG    = shamt_t'(DT_FRAC);
    localparam shamt_t S_TEMP   = shamt_t'(DT_FRAC + 2);

    // request to and response from the multiply-divide unit
    typedef struct packed {
        logic   start;
        opnd_t  a;
        opnd_t  b;
        kdiv_t  k;
        shamt_t s;
    } md_req_t;

    typedef struct packed {
        logic  done;
        opnd_t result;
    } md_resp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ev_drivetrain_sim_step.sv =====
// Electric drivetrain tick: torque, speed, power, charge, range and motor temperature.
// Each product runs through one shared multiply-divide unit; a tick takes 8 products,
// 10 when brake regeneration is active. The next input is taken the cycle after
// the result is loaded.
// Async active-low reset: speed 0, charge 100 %, temperature 25 C, normal mode, 6554 step.
// Depends on evd_pkg and evd_muldiv.
`default_nettype none

module ev_drivetrain_sim_step (
    input  logic                             clk,
    input  logic                             rst_n,
    // input transfer
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // accel_pedal [14:0], brake_pedal [29:15]
    input  logic [evd_pkg::IN_DATA_W-1:0]    s_tdata,
    // result transfer
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // speed_out [23:0], torque_out [48:24], charge_out [71:49], range_out [95:72],
    // power_out [117:96], temp_out [141:118], regen_level_out [164:142],
    // regen_active_out [165]
    output logic [evd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [evd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TORQ,
        S_REGEN,
        S_RTORQ,
        S_DRAG,
        S_SPEED,
        S_P1,
        S_P2,
        S_CHG,
        S_RANGE,
        S_TEMP,
        S_OUT
    } state_t;

    state_t                              state_reg;
    logic                                wait_reg;
    evd_pkg::mode_t                      mode_reg;
    evd_pkg::dt_t                        dt_reg;
    evd_pkg::speed_t                     speed_reg;
    evd_pkg::charge_t                    charge_reg;
    evd_pkg::temp_t                      temp_reg;
    logic                                regen_on_reg;
    logic                                m_tvalid_reg;
    logic [evd_pkg::OUT_DATA_W-1:0]      out_data_reg;

    evd_pkg::pedal_t                     accel_reg;
    evd_pkg::pedal_t                     brake_reg;
    evd_pkg::opnd_t                      torque_reg;
    evd_pkg::opnd_t                      regen_reg;
    evd_pkg::opnd_t                      drag_reg;
    evd_pkg::opnd_t                      power_reg;
    evd_pkg::range_t                     range_reg;

    evd_pkg::md_req_t                    md_req;
    evd_pkg::md_resp_t                   md_resp;

    evd_pkg::pedal_t                     accel_in;
    evd_pkg::pedal_t                     brake_in;
    evd_pkg::pedal_t                     accel_sat;
    evd_pkg::pedal_t                     brake_sat;
    evd_pkg::opnd_t                      res;
    evd_pkg::opnd_t                      torque_drive;
    evd_pkg::opnd_t                      abs_power;
    evd_pkg::opnd_t                      net_heat;
    evd_pkg::wide_t                      speed_sum;
    evd_pkg::wide_t                      charge_diff;
    evd_pkg::wide_t                      temp_sum;
    evd_pkg::speed_t                     speed_next;
    evd_pkg::charge_t                    charge_next;
    evd_pkg::temp_t                      temp_next;
    logic                                out_free;
    logic                                in_xfer;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // pedal saturation
    assign accel_in  = s_tdata[evd_pkg::PEDAL_W-1:0];
    assign brake_in  = s_tdata[2*evd_pkg::PEDAL_W-1:evd_pkg::PEDAL_W];
    assign accel_sat = (accel_in > evd_pkg::PEDAL_FULL) ? evd_pkg::PEDAL_FULL : accel_in;
    assign brake_sat = (brake_in > evd_pkg::PEDAL_FULL) ? evd_pkg::PEDAL_FULL : brake_in;

    // operand selection for the shared unit
    always_comb
    begin
        md_req.start = (state_reg != S_IDLE) && (state_reg != S_OUT) && !wait_reg;
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.k     = evd_pkg::K_ONE;
        md_req.s     = evd_pkg::S_NONE;
        unique case (state_reg)
            S_TORQ:
            begin
                md_req.a = evd_pkg::opnd_t'(accel_reg) << evd_pkg::PEDAL_SHL;
                unique case (mode_reg)
                    evd_pkg::MODE_ECO:
                    begin
                        md_req.b = evd_pkg::B_ECO;
                        md_req.k = evd_pkg::K_FIVE;
                        md_req.s = evd_pkg::S_HALF;
                    end
                    evd_pkg::MODE_SPORT:
                    begin
                        md_req.b = evd_pkg::B_SPORT;
                        md_req.k = evd_pkg::K_FIVE;
                        md_req.s = evd_pkg::S_HALF;
                    end
                    default:
                    begin
                        md_req.b = evd_pkg::B_NORMAL;
                    end
                endcase
            end
            S_REGEN:
            begin
                md_req.a = evd_pkg::opnd_t'(brake_reg) << evd_pkg::PEDAL_SHL;
                md_req.b = evd_pkg::B_REGEN;
                md_req.k = evd_pkg::K_FIVE;
                md_req.s = evd_pkg::S_HALF;
            end
            S_RTORQ:
            begin
                md_req.a = -regen_reg;
                md_req.b = evd_pkg::B_RTORQ;
                md_req.k = evd_pkg::K_FIVE;
            end
            S_DRAG:
            begin
                md_req.a = evd_pkg::opnd_t'(speed_reg);
                md_req.b = evd_pkg::B_DRAG;
                md_req.k = evd_pkg::K_DRAG;
                md_req.s = evd_pkg::S_HALF;
            end
            S_SPEED:
            begin
                md_req.a = torque_reg - drag_reg;
                md_req.b = evd_pkg::opnd_t'(dt_reg);
                md_req.k = evd_pkg::K_SPEED;
                md_req.s = evd_pkg::S_SPEED;
            end
            S_P1:
            begin
                md_req.a = torque_reg;
                md_req.b = evd_pkg::opnd_t'(speed_reg);
                md_req.k = evd_pkg::K_P1;
                md_req.s = evd_pkg::S_P1;
            end
            S_P2:
            begin
                md_req.a = torque_reg;
                md_req.b = torque_reg;
                md_req.k = evd_pkg::K_P2;
                md_req.s = evd_pkg::S_P2;
            end
            S_CHG:
            begin
                md_req.a = power_reg;
                md_req.b = evd_pkg::opnd_t'({dt_reg, 1'b0});
                md_req.k = evd_pkg::K_CHG;
                md_req.s = evd_pkg::S_CHG;
            end
            S_RANGE:
            begin
                md_req.a = evd_pkg::opnd_t'(charge_reg);
                unique case (mode_reg)
                    evd_pkg::MODE_ECO:
                    begin
                        md_req.b = evd_pkg::B_RNG_ECO;
                        md_req.k = evd_pkg::K_FIVE;
                    end
                    evd_pkg::MODE_SPORT:
                    begin
                        md_req.b = evd_pkg::B_RNG_SPORT;
                        md_req.k = evd_pkg::K_TWENTY5;
                    end
                    default:
                    begin
                        md_req.b = evd_pkg::B_RNG_NORM;
                        md_req.k = evd_pkg::K_FIVE;
                        md_req.s = evd_pkg::S_HALF;
                    end
                endcase
            end
            S_TEMP:
            begin
                md_req.a = net_heat;
                md_req.b = evd_pkg::opnd_t'(dt_reg);
                md_req.k = evd_pkg::K_TWENTY5;
                md_req.s = evd_pkg::S_TEMP;
            end
            default:
            begin
                md_req.a = '0;
            end
        endcase
    end

    evd_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .resp  (md_resp)
    );

    assign res = md_resp.result;

    // drive torque limit
    assign torque_drive = (res > evd_pkg::TORQUE_MAX) ? evd_pkg::TORQUE_MAX : res;

    // heating term: five times the power magnitude against the rise above ambient
    assign abs_power = power_reg[evd_pkg::OPND_W-1] ? -power_reg : power_reg;
    assign net_heat  = (abs_power <<< 2) + abs_power - evd_pkg::opnd_t'(temp_reg)
                     + evd_pkg::TEMP_BASE;

    // state updates with clamping
    always_comb
    begin
        speed_sum   = evd_pkg::wide_t'(speed_reg) + evd_pkg::wide_t'(res);
        charge_diff = evd_pkg::wide_t'(charge_reg) - evd_pkg::wide_t'(res);
        temp_sum    = evd_pkg::wide_t'(temp_reg) + evd_pkg::wide_t'(res);

        if (speed_sum < 0)
            speed_next = '0;
        else if (speed_sum > evd_pkg::wide_t'(evd_pkg::SPEED_MAX))
            speed_next = evd_pkg::SPEED_MAX;
        else
            speed_next = evd_pkg::speed_t'(speed_sum);

        if (charge_diff < 0)
            charge_next = '0;
        else if (charge_diff > evd_pkg::wide_t'(evd_pkg::CHARGE_FULL))
            charge_next = evd_pkg::CHARGE_FULL;
        else
            charge_next = evd_pkg::charge_t'(charge_diff);

        if (temp_sum < evd_pkg::wide_t'(evd_pkg::TEMP_MIN))
            temp_next = evd_pkg::TEMP_MIN;
        else if (temp_sum > evd_pkg::wide_t'(evd_pkg::TEMP_MAX))
            temp_next = evd_pkg::TEMP_MAX;
        else
            temp_next = evd_pkg::temp_t'(temp_sum);
    end

    // sequencer, configuration, vehicle state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wait_reg     <= 1'b0;
            mode_reg     <= evd_pkg::MODE_NORMAL;
            dt_reg       <= evd_pkg::DT_RESET;
            speed_reg    <= '0;
            charge_reg   <= evd_pkg::CHARGE_FULL;
            temp_reg     <= evd_pkg::TEMP_MIN;
            regen_on_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            // configuration write
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    evd_pkg::CFG_DRIVE_MODE: mode_reg <= evd_pkg::mode_t'(cfg_data);
                    evd_pkg::CFG_TIME_STEP:  dt_reg   <= evd_pkg::dt_t'(cfg_data);
                    default:                 mode_reg <= mode_reg;
                endcase
            end

            // result transfer frees the output register
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (md_req.start)
            begin
                wait_reg <= 1'b1;
            end
            else if (md_resp.done)
            begin
                wait_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        regen_on_reg <= (brake_sat > evd_pkg::REGEN_THRESH);
                        state_reg    <= S_TORQ;
                    end
                end
                S_TORQ:
                begin
                    if (md_resp.done)
                        state_reg <= regen_on_reg ? S_REGEN : S_DRAG;
                end
                S_REGEN: if (md_resp.done) state_reg <= S_RTORQ;
                S_RTORQ: if (md_resp.done) state_reg <= S_DRAG;
                S_DRAG:  if (md_resp.done) state_reg <= S_SPEED;
                S_SPEED:
                begin
                    if (md_resp.done)
                    begin
                        speed_reg <= speed_next;
                        state_reg <= S_P1;
                    end
                end
                S_P1:    if (md_resp.done) state_reg <= S_P2;
                S_P2:    if (md_resp.done) state_reg <= S_CHG;
                S_CHG:
                begin
                    if (md_resp.done)
                    begin
                        charge_reg <= charge_next;
                        state_reg  <= S_RANGE;
                    end
                end
                S_RANGE: if (md_resp.done) state_reg <= S_TEMP;
                S_TEMP:
                begin
                    if (md_resp.done)
                    begin
                        temp_reg  <= temp_next;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg <= evd_pkg::OUT_DATA_W'({
                            regen_on_reg,
                            regen_reg[evd_pkg::REGEN_W-1:0],
                            temp_reg,
                            power_reg[evd_pkg::POWER_W-1:0],
                            range_reg,
                            charge_reg,
                            torque_reg[evd_pkg::TORQUE_W-1:0],
                            speed_reg
                        });
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // per-tick working values
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            accel_reg <= accel_sat;
            brake_reg <= brake_sat;
            regen_reg <= '0;
        end
        if (md_resp.done)
        begin
            unique case (state_reg)
                S_TORQ:  torque_reg <= torque_drive;
                S_REGEN: regen_reg  <= res;
                S_RTORQ: torque_reg <= res;
                S_DRAG:  drag_reg   <= res;
                S_P1:    power_reg  <= res;
                S_P2:    power_reg  <= power_reg + res;
                S_RANGE: range_reg  <= evd_pkg::range_t'(res);
                default: drag_reg   <= drag_reg;
            endcase
        end
    end

    // the unit only answers a request the sequencer is waiting on
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        md_resp.done |-> wait_reg)
        else $error("multiply-divide result without a pending request");

    // an input transfer starts the first product on the next cycle
    a_accept_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> md_req.start)
        else $error("input transfer did not start the torque product");

    // vehicle state stays within its clamps
    a_state_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg <= evd_pkg::SPEED_MAX) && (charge_reg <= evd_pkg::CHARGE_FULL)
        && (temp_reg >= evd_pkg::TEMP_MIN) && (temp_reg <= evd_pkg::TEMP_MAX))
        else $error("vehicle state outside its limits");

    // a result appears only after the last update of a tick
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output step");

endmodule

`default_nettype wire

// ===== hw/rtl/evd_muldiv.sv =====
// shared multiply-divide unit: round(a*b / (k * 2^s)), ties away from zero
// one multiply, a rounding shift, then a radix-16 restoring divide by the small factor k
// depends on evd_pkg
`default_nettype none

module evd_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  evd_pkg::md_req_t  req,
    output evd_pkg::md_resp_t resp
);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_SCALE,
        U_DIV,
        U_DONE
    } u_state_t;

    u_state_t          state_reg;
    evd_pkg::divcnt_t  cnt_reg;
    evd_pkg::mag_t     ma_reg;
    evd_pkg::mag_t     mb_reg;
    logic              neg_reg;
    evd_pkg::kdiv_t    k_reg;
    evd_pkg::shamt_t   s_reg;
    evd_pkg::prod_t    prod_reg;
    evd_pkg::divd_t    quo_reg;
    evd_pkg::kdiv_t    rem_reg;

    evd_pkg::mag_t     ma_in;
    evd_pkg::mag_t     mb_in;
    evd_pkg::prod_t    half;
    evd_pkg::prod_t    rounded;
    evd_pkg::divd_t    quo_step;
    evd_pkg::kdiv_t    rem_step;
    evd_pkg::trial_t   trial;

    // operand magnitudes
    assign ma_in = req.a[evd_pkg::OPND_W-1] ? evd_pkg::mag_t'(-req.a) : evd_pkg::mag_t'(req.a);
    assign mb_in = req.b[evd_pkg::OPND_W-1] ? evd_pkg::mag_t'(-req.b) : evd_pkg::mag_t'(req.b);

    // add half the divisor, then drop the power-of-two part
    assign half    = (evd_pkg::prod_t'(k_reg) << s_reg) >> 1;
    assign rounded = prod_reg + half;

    // four quotient bits per cycle
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < evd_pkg::DIV_BITS; i++)
        begin
            trial    = {rem_step, quo_step[evd_pkg::DIVD_W-1]};
            quo_step = quo_step << 1;
            if (trial >= {1'b0, k_reg})
            begin
                rem_step    = evd_pkg::kdiv_t'(trial - {1'b0, k_reg});
                quo_step[0] = 1'b1;
            end
            else
            begin
                rem_step = evd_pkg::kdiv_t'(trial);
            end
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= U_MUL;
                    end
                end
                U_MUL:   state_reg <= U_SCALE;
                U_SCALE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    cnt_reg <= cnt_reg + evd_pkg::divcnt_t'(1);
                    if (cnt_reg == evd_pkg::divcnt_t'(evd_pkg::DIV_CYCLES - 1))
                    begin
                        state_reg <= U_DONE;
                    end
                end
                U_DONE:  state_reg <= U_IDLE;
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && req.start)
        begin
            ma_reg  <= ma_in;
            mb_reg  <= mb_in;
            neg_reg <= req.a[evd_pkg::OPND_W-1] ^ req.b[evd_pkg::OPND_W-1];
            k_reg   <= req.k;
            s_reg   <= req.s;
        end
        if (state_reg == U_MUL)
        begin
            prod_reg <= evd_pkg::prod_t'(ma_reg) * evd_pkg::prod_t'(mb_reg);
        end
        if (state_reg == U_SCALE)
        begin
            quo_reg <= evd_pkg::divd_t'(rounded >> s_reg);
            rem_reg <= '0;
        end
        if (state_reg == U_DIV)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    // signed result, valid for the single done cycle
    assign resp.done   = (state_reg == U_DONE);
    assign resp.result = neg_reg ? -evd_pkg::opnd_t'(quo_reg) : evd_pkg::opnd_t'(quo_reg);

endmodule

`default_nettype wire
